>>> design/ucut_pkg.sv
`default_nettype none
package ucut_pkg;

  localparam int CODE_W    = 10;
  localparam int RES_W     = 24;
  localparam int SUM_W     = RES_W + 1;
  localparam int DIVR_W    = 2 * RES_W;
  localparam int MV_W      = 16;
  localparam int LIM_W     = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [MV_W-1:0]   MV_MAX     = '1;
  localparam logic [RES_W-1:0]  FULL_CODE  = RES_W'(1023);
  localparam logic [DIVR_W-1:0] TAP_DIV_RST   = DIVR_W'(1);
  localparam logic [DIVR_W-1:0] SENSE_DIV_RST = '0;
  localparam logic [MV_W-1:0]   DISC_RST   = MV_W'(3000);
  localparam logic [MV_W-1:0]   RECON_RST  = MV_W'(3400);
  localparam logic [LIM_W-1:0]  LIMIT_RST  = LIM_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAP1_DIV,
    CFG_TAP2_DIV,
    CFG_TAP3_DIV,
    CFG_SENSE_DIV,
    CFG_DISCONNECT,
    CFG_RECONNECT,
    CFG_FAULT_LIM,
    CFG_RECOVERY_LIM
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CH_TAP1,
    CH_TAP2,
    CH_TAP3,
    CH_SENSE
  } chan_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PIN,
    ST_PIN_WAIT,
    ST_MUL,
    ST_DIV,
    ST_DIV_WAIT,
    ST_CELL,
    ST_RELAY,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic long_op;
  } div_req_t;

  typedef struct packed {
    logic [CODE_W-1:0] adc_tap1;
    logic [CODE_W-1:0] adc_tap2;
    logic [CODE_W-1:0] adc_tap3;
    logic [CODE_W-1:0] adc_sense;
    logic              adc_fault;
  } in_word_t;

  typedef struct packed {
    logic [MV_W-1:0] tap1_mv;
    logic [MV_W-1:0] tap2_mv;
    logic [MV_W-1:0] tap3_mv;
    logic [MV_W-1:0] cell1_mv;
    logic [MV_W-1:0] cell2_mv;
    logic [MV_W-1:0] cell3_mv;
    logic            relay_on;
    logic            read_error;
  } out_word_t;

endpackage
`default_nettype wire

>>> design/ucut_div.sv
`default_nettype none
module ucut_div #(
  parameter int DVD_W     = 38,
  parameter int SHORT_LEN = 23
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ucut_pkg::div_req_t            req,
  input  wire logic [DVD_W-1:0]              dividend,
  input  wire logic [ucut_pkg::RES_W-1:0]    divisor,
  output logic      [DVD_W-1:0]              quot,
  output logic                               done
);

  localparam int LEN_W = $clog2(DVD_W + 1);
  localparam int RES_W = ucut_pkg::RES_W;

  logic [DVD_W-1:0] q_r;
  logic [RES_W-1:0] rem_r;
  logic [LEN_W-1:0] cnt_r;
  logic             busy_r;

  logic [RES_W:0]   rem_sh;
  logic [RES_W:0]   diff;
  logic             ge;
  logic [RES_W-1:0] rem_nxt;
  logic [DVD_W-1:0] q_nxt;

  // restoring division, dividend left-aligned in q_r, one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_r, q_r[DVD_W-1]};
    diff    = rem_sh - {1'b0, divisor};
    ge      = rem_sh >= {1'b0, divisor};
    rem_nxt = ge ? diff[RES_W-1:0] : rem_sh[RES_W-1:0];
    q_nxt   = {q_r[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= req.long_op ? LEN_W'(DVD_W) : LEN_W'(SHORT_LEN);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r && cnt_r != '0) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quot = q_r;
  assign done = busy_r && (cnt_r == '0);

endmodule
`default_nettype wire

>>> design/three_cell_undervoltage_cutoff_core.sv
`default_nettype none
// Three-cell undervoltage cutoff. One scan word in, one result word out. The sense
// channel is handled first, then taps one to three; each channel runs two restoring
// divisions through one shared divider at one quotient bit per cycle (code*VREF/1023,
// then pin*(top+bottom)/bottom); the second division is skipped for each channel whose
// bottom resistor is zero, and a scan rejected for ADC fault runs no division. The input
// stalls from accept until the result is placed in the output register; that register
// frees the input side while a result waits. Configuration writes take effect at once
// and belong in idle time.
module three_cell_undervoltage_cutoff_core #(
  parameter int ADC_VREF_MV = 5000
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire ucut_pkg::in_word_t                in_word,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output ucut_pkg::out_word_t                    out_word,
  input  wire logic                              cfg_we,
  input  wire logic [ucut_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ucut_pkg::DIVR_W-1:0]       cfg_wdata
);

  localparam int CODE_W = ucut_pkg::CODE_W;
  localparam int RES_W  = ucut_pkg::RES_W;
  localparam int SUM_W  = ucut_pkg::SUM_W;
  localparam int DIVR_W = ucut_pkg::DIVR_W;
  localparam int MV_W   = ucut_pkg::MV_W;
  localparam int LIM_W  = ucut_pkg::LIM_W;
  localparam int PIN_W  = $clog2(ADC_VREF_MV + 1);
  localparam int RAW_W  = CODE_W + PIN_W;
  localparam int NUM_W  = PIN_W + SUM_W;

  localparam logic [PIN_W-1:0] VREF = PIN_W'(ADC_VREF_MV);

  // configuration
  logic [DIVR_W-1:0] tap1_div_r, tap2_div_r, tap3_div_r, sense_div_r;
  logic [MV_W-1:0]   disc_r, recon_r;
  logic [LIM_W-1:0]  fault_lim_r, recov_lim_r;

  // control and state
  ucut_pkg::state_t  state_r, state_nxt;
  ucut_pkg::chan_t   ch_r, ch_nxt;
  ucut_pkg::in_word_t in_r;
  logic              err_r;
  logic [NUM_W-1:0]  num_r;
  logic [NUM_W-1:0]  sense_r;
  logic [MV_W-1:0]   tap_r  [3];
  logic [MV_W-1:0]   cell_r [3];
  logic              relay_r, relay_nxt;
  logic [LIM_W-1:0]  fc_r, fc_nxt, rc_r, rc_nxt;
  ucut_pkg::out_word_t out_r;
  logic              out_valid_r;

  // datapath
  logic [CODE_W-1:0] code_sel;
  logic [DIVR_W-1:0] div_sel;
  logic [RES_W-1:0]  top_sel, bot_sel;
  logic [SUM_W-1:0]  res_sum;
  logic [RAW_W-1:0]  raw;
  logic [NUM_W-1:0]  num_nxt;
  logic [NUM_W-1:0]  tap_diff, tap_pos;
  logic [MV_W-1:0]   tap_sat;
  logic [MV_W-1:0]   cell_nxt [3];
  logic              any_low, all_high;
  logic              accept, out_load, bot_zero;

  ucut_pkg::div_req_t div_req;
  logic [NUM_W-1:0]   div_dvd;
  logic [RES_W-1:0]   div_dvs;
  logic [NUM_W-1:0]   div_quot;
  logic               div_done;

  ucut_div #(
    .DVD_W     (NUM_W),
    .SHORT_LEN (RAW_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quot     (div_quot),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap1_div_r  <= ucut_pkg::TAP_DIV_RST;
      tap2_div_r  <= ucut_pkg::TAP_DIV_RST;
      tap3_div_r  <= ucut_pkg::TAP_DIV_RST;
      sense_div_r <= ucut_pkg::SENSE_DIV_RST;
      disc_r      <= ucut_pkg::DISC_RST;
      recon_r     <= ucut_pkg::RECON_RST;
      fault_lim_r <= ucut_pkg::LIMIT_RST;
      recov_lim_r <= ucut_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      case (ucut_pkg::cfg_idx_t'(cfg_index))
        ucut_pkg::CFG_TAP1_DIV:     tap1_div_r  <= cfg_wdata;
        ucut_pkg::CFG_TAP2_DIV:     tap2_div_r  <= cfg_wdata;
        ucut_pkg::CFG_TAP3_DIV:     tap3_div_r  <= cfg_wdata;
        ucut_pkg::CFG_SENSE_DIV:    sense_div_r <= cfg_wdata;
        ucut_pkg::CFG_DISCONNECT:   disc_r      <= cfg_wdata[MV_W-1:0];
        ucut_pkg::CFG_RECONNECT:    recon_r     <= cfg_wdata[MV_W-1:0];
        ucut_pkg::CFG_FAULT_LIM:    fault_lim_r <= cfg_wdata[LIM_W-1:0];
        ucut_pkg::CFG_RECOVERY_LIM: recov_lim_r <= cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // channel select
  always_comb begin
    case (ch_r)
      ucut_pkg::CH_TAP1: begin
        code_sel = in_r.adc_tap1;
        div_sel  = tap1_div_r;
      end
      ucut_pkg::CH_TAP2: begin
        code_sel = in_r.adc_tap2;
        div_sel  = tap2_div_r;
      end
      ucut_pkg::CH_TAP3: begin
        code_sel = in_r.adc_tap3;
        div_sel  = tap3_div_r;
      end
      default: begin
        code_sel = in_r.adc_sense;
        div_sel  = sense_div_r;
      end
    endcase
    top_sel  = div_sel[DIVR_W-1:RES_W];
    bot_sel  = div_sel[RES_W-1:0];
    bot_zero = (bot_sel == '0);
    res_sum  = {1'b0, top_sel} + {1'b0, bot_sel};
    raw      = {{PIN_W{1'b0}}, code_sel} * {{CODE_W{1'b0}}, VREF};
    num_nxt  = NUM_W'(div_quot[PIN_W-1:0]) * NUM_W'(res_sum);
    tap_diff = div_quot - sense_r;
    tap_pos  = (div_quot > sense_r) ? tap_diff : '0;
    tap_sat  = (tap_pos[NUM_W-1:MV_W] != '0) ? ucut_pkg::MV_MAX : tap_pos[MV_W-1:0];
  end

  // cells and relay decision
  always_comb begin
    cell_nxt[0] = tap_r[0];
    cell_nxt[1] = (tap_r[1] >= tap_r[0]) ? tap_r[1] - tap_r[0] : '0;
    cell_nxt[2] = (tap_r[2] >= tap_r[1]) ? tap_r[2] - tap_r[1] : '0;
    any_low  = (cell_r[0] <= disc_r) || (cell_r[1] <= disc_r) || (cell_r[2] <= disc_r);
    all_high = (cell_r[0] >= recon_r) && (cell_r[1] >= recon_r) && (cell_r[2] >= recon_r);
    fc_nxt    = fc_r;
    rc_nxt    = rc_r;
    relay_nxt = relay_r;
    if (relay_r) begin
      if (any_low) begin
        if (fc_r < fault_lim_r) begin
          fc_nxt = fc_r + LIM_W'(1);
        end
        rc_nxt = '0;
        if (fc_nxt >= fault_lim_r) begin
          relay_nxt = 1'b0;
        end
      end else begin
        fc_nxt = '0;
      end
    end else begin
      if (all_high) begin
        if (rc_r < recov_lim_r) begin
          rc_nxt = rc_r + LIM_W'(1);
        end
        fc_nxt = '0;
        if (rc_nxt >= recov_lim_r) begin
          relay_nxt = 1'b1;
        end
      end else begin
        rc_nxt = '0;
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    ch_nxt          = ch_r;
    div_req.start   = 1'b0;
    div_req.long_op = 1'b0;
    div_dvd         = num_r;
    div_dvs         = bot_sel;
    in_stall        = (state_r != ucut_pkg::ST_IDLE);
    accept          = in_valid && !in_stall;
    out_load        = 1'b0;
    case (state_r)
      ucut_pkg::ST_IDLE: begin
        if (accept) begin
          ch_nxt    = ucut_pkg::CH_SENSE;
          state_nxt = in_word.adc_fault ? ucut_pkg::ST_DONE : ucut_pkg::ST_PIN;
        end
      end
      ucut_pkg::ST_PIN: begin
        div_req.start = 1'b1;
        div_dvd       = {raw, {(NUM_W - RAW_W){1'b0}}};
        div_dvs       = ucut_pkg::FULL_CODE;
        state_nxt     = ucut_pkg::ST_PIN_WAIT;
      end
      ucut_pkg::ST_PIN_WAIT: begin
        div_dvs = ucut_pkg::FULL_CODE;
        if (div_done) begin
          state_nxt = ucut_pkg::ST_MUL;
        end
      end
      ucut_pkg::ST_MUL: begin
        if (bot_zero) begin
          ch_nxt    = ucut_pkg::chan_t'(ch_r + 2'd1);
          state_nxt = (ch_r == ucut_pkg::CH_TAP3) ? ucut_pkg::ST_CELL : ucut_pkg::ST_PIN;
        end else begin
          state_nxt = ucut_pkg::ST_DIV;
        end
      end
      ucut_pkg::ST_DIV: begin
        div_req.start   = 1'b1;
        div_req.long_op = 1'b1;
        state_nxt       = ucut_pkg::ST_DIV_WAIT;
      end
      ucut_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          ch_nxt    = ucut_pkg::chan_t'(ch_r + 2'd1);
          state_nxt = (ch_r == ucut_pkg::CH_TAP3) ? ucut_pkg::ST_CELL : ucut_pkg::ST_PIN;
        end
      end
      ucut_pkg::ST_CELL: begin
        state_nxt = ucut_pkg::ST_RELAY;
      end
      ucut_pkg::ST_RELAY: begin
        state_nxt = ucut_pkg::ST_DONE;
      end
      ucut_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ucut_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ucut_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ucut_pkg::ST_IDLE;
      ch_r        <= ucut_pkg::CH_SENSE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r  <= in_word;
      err_r <= in_word.adc_fault;
    end
    if (state_r == ucut_pkg::ST_MUL) begin
      num_r <= num_nxt;
    end
    if (out_load) begin
      out_r.tap1_mv    <= tap_r[0];
      out_r.tap2_mv    <= tap_r[1];
      out_r.tap3_mv    <= tap_r[2];
      out_r.cell1_mv   <= cell_r[0];
      out_r.cell2_mv   <= cell_r[1];
      out_r.cell3_mv   <= cell_r[2];
      out_r.relay_on   <= relay_r;
      out_r.read_error <= err_r;
    end
  end

  // scan state: tap and cell stores, relay and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        tap_r[i]  <= '0;
        cell_r[i] <= '0;
      end
      sense_r <= '0;
      relay_r <= 1'b0;
      fc_r    <= '0;
      rc_r    <= '0;
    end else begin
      if ((state_r == ucut_pkg::ST_MUL && bot_zero) ||
          (state_r == ucut_pkg::ST_DIV_WAIT && div_done)) begin
        case (ch_r)
          ucut_pkg::CH_TAP1: tap_r[0] <= bot_zero ? '0 : tap_sat;
          ucut_pkg::CH_TAP2: tap_r[1] <= bot_zero ? '0 : tap_sat;
          ucut_pkg::CH_TAP3: tap_r[2] <= bot_zero ? '0 : tap_sat;
          default:           sense_r  <= bot_zero ? '0 : div_quot;
        endcase
      end
      if (state_r == ucut_pkg::ST_CELL) begin
        for (int i = 0; i < 3; i++) begin
          cell_r[i] <= cell_nxt[i];
        end
      end
      if (state_r == ucut_pkg::ST_RELAY) begin
        relay_r <= relay_nxt;
        fc_r    <= fc_nxt;
        rc_r    <= rc_nxt;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule
`default_nettype wire
